// ===== rtl/fpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and codes for the partition allocator
// Holds the input and result word layouts, the command, status and policy
// codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package fpa_pkg;

    // Command codes carried in the kind field
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_ALLOC  = 2'd2;

    // Placement rule held in the policy register
    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2,
        POL_NEXT  = 2'd3
    } policy_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_GRANT   = 3'd1,
        ST_EXACT   = 3'd2,
        ST_REFUSED = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_UPDATE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RESULT
    } state_t;

    // Input word
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] size_value;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_index;
        logic [15:0] remaining_size;
        logic [4:0]  entry_count;
    } out_word_t;

endpackage
`default_nettype wire

// ===== rtl/fpa_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_table: partition size store
// One write port and one read port; read data is registered, so it shows
// the entry addressed in the previous cycle.
// ----------------------------------------------------------------------------
module fpa_table #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  wire                       aclk,
    input  wire                       wr_en,
    input  wire [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire [WIDTH-1:0]           wr_data,
    input  wire [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [WIDTH-1:0]          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write the addressed entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read word
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/fit_policy_partition_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fit_policy_partition_allocator: ordered free-partition table with a
// selectable placement rule (first, best, worst or next fit)
// ----------------------------------------------------------------------------
// Usage:
//   Input words (s_valid/s_ready, s_data) clear the table, append a partition
//   or request an allocation. Each word yields exactly one result word on
//   m_valid/m_ready, m_data. The policy register is written with cfg_we and
//   cfg_wdata, by the user only while the block is idle; the block itself
//   does not enforce this. The block handles one word at a time: s_ready is
//   high only while idle. Clear, append, undefined commands and trivially
//   refused requests show their result in the cycle after acceptance. A
//   request walks the table through the single read port of the store, a
//   read step and a compare step per entry scanned, then an update step; an
//   exact fit adds a shift-down pass that reads and writes each entry moved.
//   Reset clears the entry count, the next-fit rover and the policy (first
//   fit); the size store is not cleared and needs no sweep.
//   A stalled receiver holds the result word; no new word is taken until it
//   leaves.
// ----------------------------------------------------------------------------
module fit_policy_partition_allocator #(
    parameter int SLOTS     = 16,
    parameter int SIZE_BITS = 16
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  fpa_pkg::in_word_t s_data,
    output logic              m_valid,
    input  wire               m_ready,
    output fpa_pkg::out_word_t m_data,
    input  wire               cfg_we,
    input  wire [1:0]         cfg_wdata
);

    localparam int IW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int SW    = SIZE_BITS;
    localparam int InW   = (SW > 16) ? SW : 16;
    localparam int SlotW = (IW > 4) ? IW : 4;
    localparam int CntW  = (CW > 5) ? CW : 5;

    fpa_pkg::state_t  state_reg, state_next;
    fpa_pkg::policy_t policy_reg;
    fpa_pkg::status_t status_reg, status_next;

    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] rover_reg, rover_next;
    logic [SW-1:0] req_reg, req_next;
    logic [IW-1:0] k_reg, k_next;
    logic [CW-1:0] i_reg, i_next;
    logic          found_reg, found_next;
    logic [SW-1:0] best_reg, best_next;
    logic [IW-1:0] pick_reg, pick_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic [SW-1:0] rem_reg, rem_next;

    logic          tbl_we;
    logic [IW-1:0] tbl_waddr;
    logic [SW-1:0] tbl_wdata;
    logic [IW-1:0] tbl_raddr;
    logic [SW-1:0] tbl_rdata;

    logic [InW-1:0]   size_wide;
    logic [SW-1:0]    req_in;
    logic [SW-1:0]    diff;
    logic             fits;
    logic             better;
    logic             last_entry;
    logic [InW-1:0]   rem_wide;
    logic [SlotW-1:0] slot_wide;
    logic [CntW-1:0]  cnt_wide;

    // Fit the requested size to the store width
    assign size_wide = InW'(s_data.size_value);
    assign req_in    = size_wide[SW-1:0];

    // Shared compare and subtract
    assign fits       = (tbl_rdata >= req_reg);
    assign better     = !found_reg
                        || (policy_reg == fpa_pkg::POL_BEST  && tbl_rdata < best_reg)
                        || (policy_reg == fpa_pkg::POL_WORST && tbl_rdata > best_reg);
    assign last_entry = (CW'(i_reg + 1'b1) == count_reg);
    assign diff       = best_reg - req_reg;

    fpa_table #(
        .DEPTH (SLOTS),
        .WIDTH (SW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (tbl_waddr),
        .wr_data (tbl_wdata),
        .rd_addr (tbl_raddr),
        .rd_data (tbl_rdata)
    );

    // Policy register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= fpa_pkg::POL_FIRST;
        end else if (cfg_we) begin
            policy_reg <= fpa_pkg::policy_t'(cfg_wdata);
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fpa_pkg::S_IDLE;
            count_reg <= '0;
            rover_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            rover_reg <= rover_next;
        end
    end

    // Working and result registers
    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        k_reg      <= k_next;
        i_reg      <= i_next;
        found_reg  <= found_next;
        best_reg   <= best_next;
        pick_reg   <= pick_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        rem_reg    <= rem_next;
    end

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        rover_next  = rover_reg;
        req_next    = req_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        found_next  = found_reg;
        best_next   = best_reg;
        pick_next   = pick_reg;
        status_next = status_reg;
        slot_next   = slot_reg;
        rem_next    = rem_reg;
        tbl_we      = 1'b0;
        tbl_waddr   = pick_reg;
        tbl_wdata   = req_reg;
        tbl_raddr   = k_reg;
        s_ready     = 1'b0;
        m_valid     = 1'b0;

        case (state_reg)
            fpa_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    slot_next   = '0;
                    rem_next    = '0;
                    status_next = fpa_pkg::ST_REFUSED;
                    state_next  = fpa_pkg::S_RESULT;
                    case (s_data.kind)
                        fpa_pkg::KIND_CLEAR: begin
                            count_next  = '0;
                            rover_next  = '0;
                            status_next = fpa_pkg::ST_DONE;
                        end
                        fpa_pkg::KIND_APPEND: begin
                            if (count_reg >= CW'(SLOTS)) begin
                                status_next = fpa_pkg::ST_FULL;
                            end else begin
                                tbl_we      = 1'b1;
                                tbl_waddr   = count_reg[IW-1:0];
                                tbl_wdata   = req_in;
                                count_next  = count_reg + 1'b1;
                                slot_next   = count_reg[IW-1:0];
                                status_next = fpa_pkg::ST_DONE;
                            end
                        end
                        fpa_pkg::KIND_ALLOC: begin
                            req_next = req_in;
                            if (req_in != '0 && count_reg != '0) begin
                                i_next     = '0;
                                found_next = 1'b0;
                                if (policy_reg == fpa_pkg::POL_NEXT
                                    && CW'(rover_reg) < count_reg) begin
                                    k_next = rover_reg;
                                end else begin
                                    k_next = '0;
                                end
                                state_next = fpa_pkg::S_SCAN_RD;
                            end
                        end
                        default: begin
                            status_next = fpa_pkg::ST_REFUSED;
                        end
                    endcase
                end
            end

            // Address the next entry of the scan
            fpa_pkg::S_SCAN_RD: begin
                tbl_raddr  = k_reg;
                state_next = fpa_pkg::S_SCAN_CMP;
            end

            // Compare the entry and decide whether the scan ends
            fpa_pkg::S_SCAN_CMP: begin
                if (fits && better) begin
                    found_next = 1'b1;
                    best_next  = tbl_rdata;
                    pick_next  = k_reg;
                end
                if ((fits && (policy_reg == fpa_pkg::POL_FIRST
                              || policy_reg == fpa_pkg::POL_NEXT)) || last_entry) begin
                    if (found_reg || fits) begin
                        state_next = fpa_pkg::S_UPDATE;
                    end else begin
                        status_next = fpa_pkg::ST_REFUSED;
                        slot_next   = '0;
                        rem_next    = '0;
                        state_next  = fpa_pkg::S_RESULT;
                    end
                end else begin
                    i_next = i_reg + 1'b1;
                    if (CW'(k_reg) + 1'b1 == count_reg) begin
                        k_next = '0;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                    state_next = fpa_pkg::S_SCAN_RD;
                end
            end

            // Take the request out of the chosen entry
            fpa_pkg::S_UPDATE: begin
                rover_next = pick_reg;
                slot_next  = pick_reg;
                if (diff == '0) begin
                    status_next = fpa_pkg::ST_EXACT;
                    rem_next    = '0;
                    k_next      = pick_reg;
                    state_next  = fpa_pkg::S_SHIFT_RD;
                end else begin
                    tbl_we      = 1'b1;
                    tbl_waddr   = pick_reg;
                    tbl_wdata   = diff;
                    status_next = fpa_pkg::ST_GRANT;
                    rem_next    = diff;
                    state_next  = fpa_pkg::S_RESULT;
                end
            end

            // Read the entry above the gap, or finish compaction
            fpa_pkg::S_SHIFT_RD: begin
                if (CW'(k_reg) + 1'b1 < count_reg) begin
                    tbl_raddr  = k_reg + 1'b1;
                    state_next = fpa_pkg::S_SHIFT_WR;
                end else begin
                    count_next = count_reg - 1'b1;
                    state_next = fpa_pkg::S_RESULT;
                end
            end

            // Move it down one slot
            fpa_pkg::S_SHIFT_WR: begin
                tbl_we     = 1'b1;
                tbl_waddr  = k_reg;
                tbl_wdata  = tbl_rdata;
                k_next     = k_reg + 1'b1;
                state_next = fpa_pkg::S_SHIFT_RD;
            end

            // Hold the result word until taken
            fpa_pkg::S_RESULT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = fpa_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = fpa_pkg::S_IDLE;
            end
        endcase
    end

    // Result word
    assign rem_wide  = InW'(rem_reg);
    assign slot_wide = SlotW'(slot_reg);
    assign cnt_wide  = CntW'(count_reg);

    always_comb begin
        m_data.status         = status_reg;
        m_data.slot_index     = slot_wide[3:0];
        m_data.remaining_size = rem_wide[15:0];
        m_data.entry_count    = cnt_wide[4:0];
    end

endmodule
`default_nettype wire

// ===== rtl/fpa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_checker: port-level checks for the partition allocator
// Watches the handshakes and result words of the top level.
// ----------------------------------------------------------------------------
module fpa_checker (
    input wire                aclk,
    input wire                aresetn,
    input wire                s_valid,
    input wire                s_ready,
    input wire                m_valid,
    input wire                m_ready,
    input fpa_pkg::out_word_t m_data
);

    // One word at a time: never ready for input while a result waits
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result word is pending");

    // An accepted word closes the input side for the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input still ready right after acceptance");

    // An exact grant leaves nothing in the partition
    a_exact_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == fpa_pkg::ST_EXACT) |-> m_data.remaining_size == '0)
        else $error("exact grant with nonzero remainder");

    // Refusal and full carry no slot and no remainder
    a_refused_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == fpa_pkg::ST_REFUSED
                     || m_data.status == fpa_pkg::ST_FULL))
        |-> (m_data.slot_index == '0 && m_data.remaining_size == '0))
        else $error("refused or full word carries slot or remainder");

    // Stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result word changed while stalled");

endmodule

bind fit_policy_partition_allocator fpa_checker u_fpa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

// ===== tb/tb_fit_policy_partition_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fit_policy_partition_allocator: self-checking bench for the allocator
// Drives clear, append and allocation words under all four placement rules,
// predicts every result word from a local copy of the partition table and
// compares each one field by field, with random sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_fit_policy_partition_allocator;

    localparam int SLOTS       = 16;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 80;
    localparam int PER_POLICY  = 155;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    fpa_pkg::in_word_t  s_data    = '0;
    logic               s_ready;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    fpa_pkg::out_word_t m_data;
    logic               cfg_we    = 1'b0;
    logic [1:0]         cfg_wdata = 2'd0;

    // Local copy of the allocator state
    logic [15:0]      tbl_size [SLOTS];
    int               tbl_count;
    int               tbl_rover;
    fpa_pkg::policy_t tbl_policy;

    fpa_pkg::out_word_t pending_results[$];
    int          words_sent;
    int          results_checked;
    int          error_count;
    int          status_seen[8];
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          stall_cycles;
    int          hold_req_count;
    int          hold_seen;
    int          hold_left;

    fit_policy_partition_allocator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Compute the result word of one input word and advance the table copy
    function automatic fpa_pkg::out_word_t allocator_predict(input fpa_pkg::in_word_t w);
        fpa_pkg::out_word_t r;
        logic [15:0] want;
        logic [15:0] best;
        int          pick;
        int          start;
        int          k;
        int          i;
        bit          found;
        r = '0;
        case (w.kind)
            fpa_pkg::KIND_CLEAR: begin
                tbl_count = 0;
                tbl_rover = 0;
                r.status  = fpa_pkg::ST_DONE;
            end
            fpa_pkg::KIND_APPEND: begin
                if (tbl_count >= SLOTS) begin
                    r.status = fpa_pkg::ST_FULL;
                end else begin
                    tbl_size[tbl_count] = w.size_value;
                    r.status     = fpa_pkg::ST_DONE;
                    r.slot_index = 4'(tbl_count);
                    tbl_count++;
                end
            end
            fpa_pkg::KIND_ALLOC: begin
                want  = w.size_value;
                found = 1'b0;
                pick  = 0;
                best  = '0;
                if (want != 0 && tbl_policy == fpa_pkg::POL_NEXT) begin
                    // scan from the rover, wrapping once through the table
                    start = (tbl_rover < tbl_count) ? tbl_rover : 0;
                    for (i = 0; i < tbl_count && !found; i++) begin
                        k = start + i;
                        if (k >= tbl_count) k -= tbl_count;
                        if (tbl_size[k] >= want) begin
                            found = 1'b1;
                            pick  = k;
                        end
                    end
                end else if (want != 0) begin
                    // first fit keeps the first hit; best and worst keep the
                    // first of equal candidates
                    for (i = 0; i < tbl_count; i++) begin
                        if (tbl_size[i] >= want && (!found ||
                            (tbl_policy == fpa_pkg::POL_BEST  && tbl_size[i] < best) ||
                            (tbl_policy == fpa_pkg::POL_WORST && tbl_size[i] > best))) begin
                            found = 1'b1;
                            best  = tbl_size[i];
                            pick  = i;
                        end
                    end
                end
                if (!found) begin
                    r.status = fpa_pkg::ST_REFUSED;
                end else begin
                    tbl_rover    = pick;
                    r.slot_index = 4'(pick);
                    if (tbl_size[pick] == want) begin
                        // close the gap left by the used-up partition
                        for (i = pick; i + 1 < tbl_count; i++)
                            tbl_size[i] = tbl_size[i + 1];
                        tbl_count--;
                        r.status = fpa_pkg::ST_EXACT;
                    end else begin
                        tbl_size[pick]   = tbl_size[pick] - want;
                        r.remaining_size = tbl_size[pick];
                        r.status         = fpa_pkg::ST_GRANT;
                    end
                end
            end
            default: begin
                r.status = fpa_pkg::ST_REFUSED;
            end
        endcase
        r.entry_count = 5'(tbl_count);
        return r;
    endfunction

    task automatic report_error(input string what);
        $display("%0t ERROR: %s", $time, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s: got %0h, expected %0h",
                                   results_checked, name, got, want));
    endtask

    // Offer one word, wait for the handshake, queue its expected result
    task automatic send_word(input fpa_pkg::in_word_t w);
        int gap;
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            gap = ($urandom_range(9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(allocator_predict(w));
        words_sent++;
    endtask

    // Drop valid and wait until every expected result word has left
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic set_policy(input fpa_pkg::policy_t p);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= p;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        tbl_policy = p;
    endtask

    // One well-formed pass: clear, fill with partitions, then requests mixed with appends
    task automatic send_table_sequence();
        int          n_parts;
        int          n_reqs;
        int          size_cap;
        logic [15:0] base;
        logic [15:0] sz;
        case ($urandom_range(3))
            0:       size_cap = 15;
            1:       size_cap = 100;
            2:       size_cap = 4000;
            default: size_cap = 65535;
        endcase
        send_word('{kind: fpa_pkg::KIND_CLEAR, size_value: 16'($urandom_range(65535))});
        n_parts = $urandom_range(1, 18);
        repeat (n_parts) begin
            sz = ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom_range(1, size_cap));
            send_word('{kind: fpa_pkg::KIND_APPEND, size_value: sz});
        end
        n_reqs = $urandom_range(3, 20);
        repeat (n_reqs) begin
            base = (tbl_count != 0) ? tbl_size[$urandom_range(tbl_count - 1)] : 16'd1;
            case ($urandom_range(9))
                0, 1, 2: sz = base;
                3, 4, 5: sz = (base > 1) ? 16'($urandom_range(1, base - 1)) : 16'd1;
                6:       sz = (base == 16'hFFFF) ? base
                                : 16'($urandom_range(int'(base) + 1, 65535));
                7:       sz = $urandom_range(1) ? 16'd0 : 16'($urandom_range(65535));
                8:       sz = 16'($urandom_range(65535));
                default: sz = 16'hxxxx;
            endcase
            if (sz === 16'hxxxx)
                send_word('{kind: fpa_pkg::KIND_APPEND,
                            size_value: 16'($urandom_range(1, size_cap))});
            else
                send_word('{kind: fpa_pkg::KIND_ALLOC, size_value: sz});
        end
    endtask

    // Empty-table refusal, undefined command, size extremes, full table
    task automatic test_reset_and_extremes();
        send_word('{kind: fpa_pkg::KIND_ALLOC,  size_value: 16'd7});
        send_word('{kind: 2'd3,                 size_value: 16'hFFFF});
        send_word('{kind: fpa_pkg::KIND_APPEND, size_value: 16'd0});
        send_word('{kind: fpa_pkg::KIND_APPEND, size_value: 16'hFFFF});
        send_word('{kind: fpa_pkg::KIND_ALLOC,  size_value: 16'd0});
        repeat (SLOTS - 2)
            send_word('{kind: fpa_pkg::KIND_APPEND,
                        size_value: 16'($urandom_range(1, 500))});
        send_word('{kind: fpa_pkg::KIND_APPEND, size_value: 16'd9});
        send_word('{kind: fpa_pkg::KIND_ALLOC,  size_value: 16'hFFFF});
        send_word('{kind: fpa_pkg::KIND_CLEAR,  size_value: 16'd0});
    endtask

    // Best-fit tie breaking and a worst-fit pick; next-fit wrap, exact removal
    // under the rover, and a rover left past the end of the table
    task automatic test_policy_selection();
        send_word('{kind: fpa_pkg::KIND_APPEND, size_value: 16'd40});
        send_word('{kind: fpa_pkg::KIND_APPEND, size_value: 16'd25});
        send_word('{kind: fpa_pkg::KIND_APPEND, size_value: 16'd60});
        send_word('{kind: fpa_pkg::KIND_APPEND, size_value: 16'd25});
        set_policy(fpa_pkg::POL_BEST);
        send_word('{kind: fpa_pkg::KIND_ALLOC, size_value: 16'd20});
        set_policy(fpa_pkg::POL_WORST);
        send_word('{kind: fpa_pkg::KIND_ALLOC, size_value: 16'd10});
        set_policy(fpa_pkg::POL_NEXT);
        send_word('{kind: fpa_pkg::KIND_ALLOC, size_value: 16'd45});
        send_word('{kind: fpa_pkg::KIND_ALLOC, size_value: 16'd30});
        send_word('{kind: fpa_pkg::KIND_ALLOC, size_value: 16'd10});
        send_word('{kind: fpa_pkg::KIND_ALLOC, size_value: 16'd25});
        send_word('{kind: fpa_pkg::KIND_ALLOC, size_value: 16'd5});
        send_word('{kind: fpa_pkg::KIND_CLEAR, size_value: 16'd0});
    endtask

    // Stall the receiver for a long stretch while words keep coming
    task automatic test_backpressure();
        drain_results();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req_count <= hold_req_count + 1;
        repeat (3) send_word('{kind: fpa_pkg::KIND_APPEND,
                               size_value: 16'($urandom_range(1, 99))});
        repeat (5) send_word('{kind: fpa_pkg::KIND_ALLOC,
                               size_value: 16'($urandom_range(1, 40))});
        drain_results();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct);
        fpa_pkg::policy_t order[4];
        int               stop_at;
        order = '{fpa_pkg::POL_FIRST, fpa_pkg::POL_BEST,
                  fpa_pkg::POL_WORST, fpa_pkg::POL_NEXT};
        drain_results();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        foreach (order[p]) begin
            set_policy(order[p]);
            stop_at = words_sent + PER_POLICY;
            while (words_sent < stop_at) begin
                if ($urandom_range(9) == 0)
                    send_word('{kind: 2'($urandom_range(3)),
                                size_value: 16'($urandom_range(65535))});
                else
                    send_table_sequence();
            end
        end
    endtask

    // Receiver: random stalls, plus a long hold when one is requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end else if (hold_seen != hold_req_count) begin
            hold_seen <= hold_req_count;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge aclk) begin : check_result
        fpa_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_error($sformatf("unexpected result word %0h", m_data));
            end else begin
                want = pending_results.pop_front();
                check_field("status",         16'(m_data.status),      16'(want.status));
                check_field("slot_index",     16'(m_data.slot_index),  16'(want.slot_index));
                check_field("remaining_size", m_data.remaining_size,   want.remaining_size);
                check_field("entry_count",    16'(m_data.entry_count), 16'(want.entry_count));
                status_seen[want.status]++;
                results_checked++;
            end
        end
    end

    // Count cycles in which neither channel moves a word
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        tbl_count      = 0;
        tbl_rover      = 0;
        tbl_policy     = fpa_pkg::POL_FIRST;
        words_sent     = 0;
        results_checked = 0;
        error_count    = 0;
        hold_req_count = 0;
        tx_idle_pct    = 18;
        rx_idle_pct    = 56;
        foreach (status_seen[i]) status_seen[i] = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_and_extremes();
        test_policy_selection();
        test_backpressure();
        test_random_traffic(18, 56);
        test_random_traffic(56, 18);
        test_random_traffic(0, 0);

        // wait out the last results, then watch for stray words
        drain_results();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (pending_results.size() != 0)
            report_error($sformatf("%0d result words never arrived", pending_results.size()));

        $display("Sent %0d words under all four placement rules and three stall profiles;",
                 words_sent);
        $display("checked %0d results: done %0d, grant %0d, exact %0d, refused %0d, full %0d",
                 results_checked, status_seen[fpa_pkg::ST_DONE],
                 status_seen[fpa_pkg::ST_GRANT], status_seen[fpa_pkg::ST_EXACT],
                 status_seen[fpa_pkg::ST_REFUSED], status_seen[fpa_pkg::ST_FULL]);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fpa_pkg.sv
rtl/fpa_table.sv
rtl/fit_policy_partition_allocator.sv
rtl/fpa_checker.sv
tb/tb_fit_policy_partition_allocator.sv
